// ===== rtl/core/speck64_96_block_cipher_assert.svh =====
// assertion macros for the speck64/96 cipher core
`ifndef SPECK64_96_BLOCK_CIPHER_ASSERT_SVH
`define SPECK64_96_BLOCK_CIPHER_ASSERT_SVH

`ifndef SYNTHESIS
`define SPK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SPK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPK_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/core/speck_pkg.sv =====
// shared constants, types and rotate helpers for the speck64/96 core
`timescale 1ns / 1ps

package speck_pkg;

    localparam int NUM_ROUNDS = 26;
    localparam int RND_W      = $clog2(NUM_ROUNDS);
    localparam int WORD_W     = 32;
    localparam int ALPHA      = 8;
    localparam int BETA       = 3;
    localparam int REG_CNT    = 3;
    localparam int ADDR_W     = 4;
    localparam int IDX_W      = 2;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [RND_W-1:0]  t_rnd;
    typedef logic [IDX_W-1:0]  t_reg_idx;

    localparam t_rnd LAST_RND = t_rnd'(NUM_ROUNDS - 1);

    localparam t_reg_idx REG_KEY0 = t_reg_idx'(0);
    localparam t_reg_idx REG_KEY1 = t_reg_idx'(1);
    localparam t_reg_idx REG_KEY2 = t_reg_idx'(2);

    // controller to datapath command bundle
    typedef struct packed {
        logic load;            // take a new input item into the round registers
        logic round;           // apply one round to the working words
        logic decrypt;         // round direction
        logic out_from_round;  // result register takes the round output
        logic out_from_reg;    // result register takes the working words
        logic rd_en;           // fetch a round key
        t_rnd rd_addr;
        logic key_init;        // start the key schedule
        logic key_step;        // one key schedule step
        t_rnd key_idx;         // schedule step number
    } t_dp_cmd;

    function automatic t_word rot_r(input t_word v, input int s);
        return (v >> s) | (v << (WORD_W - s));
    endfunction

    function automatic t_word rot_l(input t_word v, input int s);
        return (v << s) | (v >> (WORD_W - s));
    endfunction

endpackage

// ===== rtl/core/speck_ctrl.sv =====
// control state machine: key expansion, round sequencing and result handoff
`timescale 1ns / 1ps
`include "speck64_96_block_cipher_assert.svh"

module speck_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr,
    input  logic              i_in_valid,
    input  logic              i_in_mode,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output speck_pkg::t_dp_cmd o_cmd
);
    import speck_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RUN   = 3'd1;
    localparam logic [2:0] S_HOLD  = 3'd2;
    localparam logic [2:0] S_KINIT = 3'd3;
    localparam logic [2:0] S_KEXP  = 3'd4;

    logic [2:0] r_state, n_state;
    t_rnd       r_cnt, n_cnt;
    logic       r_mode, n_mode;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    // a key write in the same cycle wins over a new item
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_wr;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_mode      = r_mode;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                // first key fetch goes out with the accept
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = i_in_mode ? LAST_RND : '0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_mode     = i_in_mode;
                    n_cnt      = '0;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.round   = 1'b1;
                o_cmd.decrypt = r_mode;
                if (r_cnt == LAST_RND) begin
                    if (out_free) begin
                        o_cmd.out_from_round = 1'b1;
                        n_out_valid          = 1'b1;
                        n_state              = S_IDLE;
                    end else begin
                        n_state = S_HOLD;
                    end
                end else begin
                    // prefetch the key for the next round
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_addr = r_mode ? (LAST_RND - r_cnt - t_rnd'(1))
                                           : (r_cnt + t_rnd'(1));
                    n_cnt         = r_cnt + t_rnd'(1);
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    o_cmd.out_from_reg = 1'b1;
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_KINIT: begin
                o_cmd.key_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_KEXP;
            end
            S_KEXP: begin
                o_cmd.key_step = 1'b1;
                o_cmd.key_idx  = r_cnt;
                if (r_cnt == LAST_RND - t_rnd'(1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + t_rnd'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // any key write restarts the schedule
        if (i_cfg_wr) begin
            n_state = S_KINIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_mode      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_mode      <= n_mode;
            r_out_valid <= n_out_valid;
        end
    end

    `SPK_ASSERT(a_no_accept_in_kexp, i_clk, i_rst_n,
        (r_state == S_KINIT || r_state == S_KEXP) |-> !o_in_ready,
        "item accepted during key expansion")
    `SPK_ASSERT(a_cnt_bound, i_clk, i_rst_n,
        (r_state == S_RUN || r_state == S_KEXP) |-> (r_cnt <= LAST_RND),
        "round counter out of range")
    `SPK_ASSERT(a_rd_addr_bound, i_clk, i_rst_n,
        o_cmd.rd_en |-> (o_cmd.rd_addr <= LAST_RND),
        "round key read beyond store")
    `SPK_ASSERT_NEXT(a_cfg_restart, i_clk, i_rst_n,
        i_cfg_wr, r_state == S_KINIT,
        "key write did not restart schedule")
    `SPK_ASSERT_NEXT(a_result_out, i_clk, i_rst_n,
        r_state == S_RUN && r_cnt == LAST_RND && !r_out_valid, o_out_valid,
        "finished item not presented")

endmodule

// ===== rtl/core/speck_dp.sv =====
// datapath: round key store, key schedule unit, round unit and result register
`timescale 1ns / 1ps

module speck_dp (
    input  logic               i_clk,
    input  speck_pkg::t_dp_cmd i_cmd,
    input  speck_pkg::t_word   i_key0,
    input  speck_pkg::t_word   i_key1,
    input  speck_pkg::t_word   i_key2,
    input  speck_pkg::t_word   i_in_x,
    input  speck_pkg::t_word   i_in_y,
    output speck_pkg::t_word   o_out_x,
    output speck_pkg::t_word   o_out_y
);
    import speck_pkg::*;

    t_word r_rk_mem [NUM_ROUNDS];
    t_word r_rk_rd;

    t_word r_la, r_lb, r_ks_rk;
    t_word sched_nl, sched_rk;

    t_word r_x, r_y;
    t_word rnd_x, rnd_y;
    t_word enc_x, enc_y, dec_x, dec_y;
    t_word r_out_x, r_out_y;

    // key schedule step
    assign sched_nl = (r_ks_rk + rot_r(r_la, ALPHA)) ^ t_word'(i_cmd.key_idx);
    assign sched_rk = rot_l(r_ks_rk, BETA) ^ sched_nl;

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_init) begin
            r_rk_mem[0] <= i_key0;
        end else if (i_cmd.key_step) begin
            r_rk_mem[i_cmd.key_idx + t_rnd'(1)] <= sched_rk;
        end
        if (i_cmd.rd_en) begin
            r_rk_rd <= r_rk_mem[i_cmd.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_init) begin
            r_la    <= i_key1;
            r_lb    <= i_key2;
            r_ks_rk <= i_key0;
        end else if (i_cmd.key_step) begin
            r_la    <= r_lb;
            r_lb    <= sched_nl;
            r_ks_rk <= sched_rk;
        end
    end

    // one round either way
    always_comb begin
        enc_x = (rot_r(r_x, ALPHA) + r_y) ^ r_rk_rd;
        enc_y = rot_l(r_y, BETA) ^ enc_x;
        dec_y = rot_r(r_y ^ r_x, BETA);
        dec_x = rot_l((r_x ^ r_rk_rd) - dec_y, ALPHA);
        rnd_x = i_cmd.decrypt ? dec_x : enc_x;
        rnd_y = i_cmd.decrypt ? dec_y : enc_y;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_in_x;
            r_y <= i_in_y;
        end else if (i_cmd.round) begin
            r_x <= rnd_x;
            r_y <= rnd_y;
        end
        if (i_cmd.out_from_round) begin
            r_out_x <= rnd_x;
            r_out_y <= rnd_y;
        end else if (i_cmd.out_from_reg) begin
            r_out_x <= r_x;
            r_out_y <= r_y;
        end
    end

    assign o_out_x = r_out_x;
    assign o_out_y = r_out_y;

endmodule

// ===== rtl/core/speck64_96_block_cipher.sv =====
// speck64/96 block cipher top level: key registers, stream ports and core
//
//  channel   dir  handshake                fields (low bit first)
//  s_axis    in   tvalid/tready            tuser: mode; tdata: word_x, word_y
//  m_axis    out  tvalid/tready            tdata: out_x, out_y
//  apb       in   psel/penable/pwrite      key_word_0 @0x0, _1 @0x4, _2 @0x8
//
//  an item runs one round per cycle, with one round key read from the key
//  store for each round; ready returns after the last round once the result
//  register is free. a key write starts the expansion, one round key per
//  cycle, during which no item is taken. the result register lets the next
//  item in while a result waits; a stalled result holds the core after its
//  last round. reset clears control and key words; the key store is undefined
//  until a key write, so encrypting before any key write is undefined.
`timescale 1ns / 1ps

module speck64_96_block_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] word_x, [63:32] word_y
    input  logic        s_axis_tuser,   // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] out_x, [63:32] out_y
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [speck_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import speck_pkg::*;

    t_word    r_key0, r_key1, r_key2;
    t_reg_idx reg_idx;
    logic     wr_en;
    logic     cfg_wr;
    t_dp_cmd  cmd;
    t_word    out_x, out_y;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        cfg_wr = 1'b0;
        prdata = '0;
        unique case (reg_idx)
            REG_KEY0: begin
                cfg_wr = wr_en;
                prdata = r_key0;
            end
            REG_KEY1: begin
                cfg_wr = wr_en;
                prdata = r_key1;
            end
            REG_KEY2: begin
                cfg_wr = wr_en;
                prdata = r_key2;
            end
            default: begin
                cfg_wr = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0 <= '0;
            r_key1 <= '0;
            r_key2 <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_KEY0: begin
                    r_key0 <= pwdata;
                end
                REG_KEY1: begin
                    r_key1 <= pwdata;
                end
                REG_KEY2: begin
                    r_key2 <= pwdata;
                end
                default: begin
                    r_key0 <= r_key0;
                end
            endcase
        end
    end

    speck_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (cfg_wr),
        .i_in_valid  (s_axis_tvalid),
        .i_in_mode   (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    speck_dp u_dp (
        .i_clk   (i_clk),
        .i_cmd   (cmd),
        .i_key0  (r_key0),
        .i_key1  (r_key1),
        .i_key2  (r_key2),
        .i_in_x  (s_axis_tdata[31:0]),
        .i_in_y  (s_axis_tdata[63:32]),
        .o_out_x (out_x),
        .o_out_y (out_y)
    );

    assign m_axis_tdata = {out_y, out_x};

endmodule

// ===== verif/speck64_96_block_cipher_test.sv =====
// self-checking testbench for the speck64/96 block cipher
`timescale 1ns / 1ps

module speck64_96_block_cipher_test;
    import speck_pkg::*;

    localparam int   HALF_PERIOD   = 6;
    localparam int   RESET_CYCLES  = 9;
    localparam int   SETTLE_CYCLES = 40;
    localparam int   HOLD_CYCLES   = 400;
    localparam int   PHASE_ITEMS   = 200;
    localparam int   BURST_ITEMS   = 40;
    localparam int   KEY_PHASES    = 7;
    localparam int   CYCLE_LIMIT   = 1500000;
    localparam int   ERRS_SHOWN    = 10;
    localparam logic MODE_ENC      = 1'b0;
    localparam logic MODE_DEC      = 1'b1;

    typedef struct packed {
        t_word x;
        t_word y;
    } block_t;

    typedef struct packed {
        logic  mode;
        t_word x;
        t_word y;
        logic  known;  // result below is typed in, not predicted
        t_word kx;
        t_word ky;
    } vector_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [63:0]         s_axis_tdata;   // [31:0] word_x, [63:32] word_y
    logic                s_axis_tuser;   // [0] mode
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [63:0]         m_axis_tdata;   // [31:0] out_x, [63:32] out_y
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    t_word  key_word [REG_CNT];
    t_word  round_key [NUM_ROUNDS];
    block_t expected_blocks [$];
    int     mismatch_count = 0;
    int     cycle_count    = 0;
    bit     hold_req       = 1'b0;
    bit     tx_calm        = 1'b0;

    vector_t directed_rows [14] = '{
        // published speck64/96 vector, x word first
        '{MODE_ENC, 32'h74614620, 32'h736e6165, 1'b1, 32'h9f7952ec, 32'h4175946c},
        '{MODE_DEC, 32'h9f7952ec, 32'h4175946c, 1'b1, 32'h74614620, 32'h736e6165},
        '{MODE_ENC, 32'h00000000, 32'h00000000, 1'b0, 32'h0, 32'h0},
        '{MODE_DEC, 32'h00000000, 32'h00000000, 1'b0, 32'h0, 32'h0},
        '{MODE_ENC, 32'hffffffff, 32'hffffffff, 1'b0, 32'h0, 32'h0},
        '{MODE_DEC, 32'hffffffff, 32'hffffffff, 1'b0, 32'h0, 32'h0},
        '{MODE_ENC, 32'h00000000, 32'hffffffff, 1'b0, 32'h0, 32'h0},
        '{MODE_ENC, 32'hffffffff, 32'h00000000, 1'b0, 32'h0, 32'h0},
        '{MODE_DEC, 32'h00000001, 32'h80000000, 1'b0, 32'h0, 32'h0},
        '{MODE_ENC, 32'h80000000, 32'h00000001, 1'b0, 32'h0, 32'h0},
        '{MODE_ENC, 32'haaaaaaaa, 32'h55555555, 1'b0, 32'h0, 32'h0},
        '{MODE_DEC, 32'h55555555, 32'haaaaaaaa, 1'b0, 32'h0, 32'h0},
        '{MODE_ENC, 32'h12345678, 32'h9abcdef0, 1'b0, 32'h0, 32'h0},
        '{MODE_DEC, 32'hfedcba98, 32'h76543210, 1'b0, 32'h0, 32'h0}
    };

    speck64_96_block_cipher dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial i_clk = 1'b0;
    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic flag_error(string msg);
        mismatch_count++;
        if (mismatch_count <= ERRS_SHOWN) begin
            $display("%s", msg);
        end
    endtask

    // speck rounds over the shadow round keys
    function automatic block_t predict_block(logic mode, t_word x, t_word y);
        t_word a;
        t_word b;
        a = x;
        b = y;
        if (mode == MODE_ENC) begin
            for (int r = 0; r < NUM_ROUNDS; r++) begin
                a = {a[7:0], a[31:8]} + b;
                a = a ^ round_key[r];
                b = {b[28:0], b[31:29]} ^ a;
            end
        end else begin
            for (int r = NUM_ROUNDS - 1; r >= 0; r--) begin
                b = b ^ a;
                b = {b[2:0], b[31:3]};
                a = (a ^ round_key[r]) - b;
                a = {a[23:0], a[31:24]};
            end
        end
        return '{x: a, y: b};
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap(bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic t_word pick_word();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 32'h00000000;
        if (roll == 1) return 32'hffffffff;
        if (roll == 2) return t_word'(1) << $urandom_range(0, WORD_W - 1);
        return $urandom;
    endfunction

    task automatic cfg_write(t_reg_idx idx, t_word val);
        t_word la;
        t_word lb;
        t_word rk;
        t_word nl;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // any mapped write re-expands the whole schedule
        if (idx < REG_CNT) begin
            key_word[idx] = val;
            la = key_word[REG_KEY1];
            lb = key_word[REG_KEY2];
            rk = key_word[REG_KEY0];
            round_key[0] = rk;
            for (int n = 0; n < NUM_ROUNDS - 1; n++) begin
                nl = (rk + {la[7:0], la[31:8]}) ^ t_word'(n);
                rk = {rk[28:0], rk[31:29]} ^ nl;
                round_key[n + 1] = rk;
                la = lb;
                lb = nl;
            end
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_keys();
        for (int i = 0; i < REG_CNT; i++) begin
            @(negedge i_clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {t_reg_idx'(i), 2'b00};
            @(negedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            if (prdata !== key_word[i]) begin
                flag_error($sformatf("key_word_%0d read: expected %h, got %h",
                                     i, key_word[i], prdata));
            end
            @(negedge i_clk);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    task automatic send_block(logic mode, t_word x, t_word y, logic known, block_t known_out);
        int gap;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_blocks.push_back(known ? known_out : predict_block(mode, x, y));
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) == 0) tx_calm = !tx_calm;
            send_block(logic'($urandom_range(0, 1)), pick_word(), pick_word(), 1'b0, '0);
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_blocks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : result_check
        block_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_blocks.size() == 0) begin
                flag_error($sformatf("result %h with nothing pending", m_axis_tdata));
            end else begin
                want = expected_blocks.pop_front();
                if (m_axis_tdata[31:0] !== want.x) begin
                    flag_error($sformatf("out_x: expected %h, got %h",
                                         want.x, m_axis_tdata[31:0]));
                end
                if (m_axis_tdata[63:32] !== want.y) begin
                    flag_error($sformatf("out_y: expected %h, got %h",
                                         want.y, m_axis_tdata[63:32]));
                end
            end
        end
    end

    // result side: random stalls, calm stretches, one long hold on request
    initial begin : result_sink
        int stall_left;
        bit calm;
        stall_left    = 0;
        calm          = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 299) == 0) calm = !calm;
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                stall_left = pick_gap(calm);
                m_axis_tready <= (stall_left == 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    initial begin : stimulus
        int mask;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_ENC;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        for (int i = 0; i < REG_CNT; i++) key_word[i] = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // the store is only valid once a key write has expanded it
        cfg_write(REG_KEY0, 32'h03020100);
        cfg_write(REG_KEY1, 32'h0b0a0908);
        cfg_write(REG_KEY2, 32'h13121110);
        check_keys();
        foreach (directed_rows[i]) begin
            send_block(directed_rows[i].mode, directed_rows[i].x, directed_rows[i].y,
                       directed_rows[i].known,
                       '{x: directed_rows[i].kx, y: directed_rows[i].ky});
        end
        drain_results();

        for (int i = 0; i < REG_CNT; i++) cfg_write(t_reg_idx'(i), 32'h00000000);
        check_keys();
        run_random(PHASE_ITEMS);
        drain_results();

        for (int i = 0; i < REG_CNT; i++) cfg_write(t_reg_idx'(i), 32'hffffffff);
        check_keys();
        run_random(PHASE_ITEMS);
        drain_results();

        // write past the last key register is dropped, keys stay put
        cfg_write(t_reg_idx'(REG_CNT), $urandom);
        check_keys();
        tx_calm  = 1'b1;
        hold_req = 1'b1;
        run_random(BURST_ITEMS);
        tx_calm = 1'b0;
        run_random(PHASE_ITEMS - BURST_ITEMS);
        drain_results();

        for (int p = 0; p < KEY_PHASES; p++) begin
            mask = $urandom_range(1, 7);
            for (int i = 0; i < REG_CNT; i++) begin
                if (mask[i]) cfg_write(t_reg_idx'(i), pick_word());
            end
            check_keys();
            run_random(PHASE_ITEMS);
            drain_results();
        end

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
